// ----- hw/rtl/hslrcc_pkg.sv -----
// Shared types, constants and the Gaussian lookup table for the HSL colour classifier.
`timescale 1ns / 1ps

package hslrcc_pkg;

  // Table resolution and spread of the Gaussian weight.
  localparam int GAUSS_FRAC_BITS = 12;
  localparam int SIGMA           = 10;

  localparam int NUM_SETS    = 3;
  localparam int NUM_CLASSES = 6;
  localparam int GTAB_LEN    = 181;

  // Field widths.
  localparam int HUE_W   = 9;
  localparam int PCT_W   = 7;
  localparam int SET_W   = 2;
  localparam int CLASS_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int DH_W    = 8;   // wrapped hue distance, 0..180
  localparam int GIDX_W  = 8;   // index into the Gaussian table

  // A table entry reaches 2^GAUSS_FRAC_BITS, a score seven times that.
  localparam int GAUSS_W = GAUSS_FRAC_BITS + 1;
  localparam int SCORE_W = GAUSS_FRAC_BITS + 4;

  // Hue geometry.
  localparam logic [HUE_W-1:0] HUE_FULL = HUE_W'(360);
  localparam logic [HUE_W-1:0] HUE_HALF = HUE_W'(180);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_LUM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_SAT  = 1'b1;

  // Register reset values.
  localparam logic [PCT_W-1:0] WHITE_LUM_RESET = PCT_W'(100);
  localparam logic [PCT_W-1:0] BLUE_SAT_RESET  = PCT_W'(70);

  // Latency from an accepted start to the result strobe.
  localparam int PIPE_DEPTH = 4;

  // Reference set codes.
  localparam logic [SET_W-1:0] SET_FIELD = 2'd0;
  localparam logic [SET_W-1:0] SET_ARENA = 2'd2;

  typedef enum logic [CLASS_W-1:0] {
    CLS_WHITE,
    CLS_BLACK,
    CLS_RED,
    CLS_YELLOW,
    CLS_GREEN,
    CLS_BLUE
  } color_class_t;

  typedef struct packed {
    logic [HUE_W-1:0] h;
    logic [PCT_W-1:0] s;
    logic [PCT_W-1:0] l;
  } ref_color_t;

  // Reference colours, [set][class] in class order white to blue.
  localparam ref_color_t REF_ROM [NUM_SETS][NUM_CLASSES] = '{
    '{ '{9'd300, 7'd5, 7'd100}, '{9'd252, 7'd24, 7'd4}, '{9'd3, 7'd53, 7'd52},
       '{9'd40, 7'd57, 7'd58}, '{9'd125, 7'd56, 7'd35}, '{9'd218, 7'd81, 7'd42} },
    '{ '{9'd300, 7'd5, 7'd100}, '{9'd252, 7'd24, 7'd4}, '{9'd2, 7'd84, 7'd22},
       '{9'd38, 7'd84, 7'd23}, '{9'd142, 7'd70, 7'd11}, '{9'd220, 7'd96, 7'd23} },
    '{ '{9'd300, 7'd5, 7'd100}, '{9'd252, 7'd24, 7'd4}, '{9'd3, 7'd53, 7'd52},
       '{9'd40, 7'd57, 7'd58}, '{9'd125, 7'd56, 7'd35}, '{9'd218, 7'd81, 7'd42} }
  };

  typedef logic [GTAB_LEN-1:0][GAUSS_W-1:0] gtab_t;

  // Terms of the alternating series for exp(-1 / (2 sigma^2)) in Q32.
  localparam logic [63:0] GS_DIV = 64'(2 * SIGMA * SIGMA);
  localparam logic [63:0] GS_T0  = 64'd1 << 32;
  localparam logic [63:0] GS_T1  = GS_T0 / (GS_DIV * 64'd1);
  localparam logic [63:0] GS_T2  = GS_T1 / (GS_DIV * 64'd2);
  localparam logic [63:0] GS_T3  = GS_T2 / (GS_DIV * 64'd3);
  localparam logic [63:0] GS_T4  = GS_T3 / (GS_DIV * 64'd4);
  localparam logic [63:0] GS_T5  = GS_T4 / (GS_DIV * 64'd5);
  localparam logic [63:0] GS_T6  = GS_T5 / (GS_DIV * 64'd6);
  localparam logic [63:0] GS_T7  = GS_T6 / (GS_DIV * 64'd7);
  localparam logic [63:0] GS_T8  = GS_T7 / (GS_DIV * 64'd8);
  localparam logic [63:0] GS_T9  = GS_T8 / (GS_DIV * 64'd9);
  localparam logic [63:0] GS_T10 = GS_T9 / (GS_DIV * 64'd10);
  localparam logic [63:0] GS_T11 = GS_T10 / (GS_DIV * 64'd11);
  localparam logic [63:0] GS_Q   = (GS_T0 + GS_T2 + GS_T4 + GS_T6 + GS_T8 + GS_T10)
                                 - (GS_T1 + GS_T3 + GS_T5 + GS_T7 + GS_T9 + GS_T11);

  // Builds G(d) = exp(-d^2 / (2 sigma^2)) in Q32 from the series above,
  // then rounds each entry to GAUSS_FRAC_BITS. Evaluated at elaboration only.
  function automatic gtab_t build_gtab();
    gtab_t       tab;
    logic [63:0] q2;
    logic [63:0] p;
    logic [63:0] g;
    logic [63:0] half;
    q2   = (GS_Q * GS_Q) >> 32;
    g    = 64'd1 << 32;
    p    = GS_Q;
    half = 64'd1 << (31 - GAUSS_FRAC_BITS);
    for (int d = 0; d < GTAB_LEN; d++) begin
      if (d > 0) begin
        g = (g * p) >> 32;
        p = (p * q2) >> 32;
      end
      tab[d] = GAUSS_W'((g + half) >> (32 - GAUSS_FRAC_BITS));
    end
    return tab;
  endfunction

  localparam gtab_t GTAB = build_gtab();

  // Control that travels down the pipeline with each transaction.
  typedef struct packed {
    logic valid;
    logic white;
    logic blue_ok;
  } ctl_t;

  typedef struct packed {
    ctl_t                              ctl;
    logic [NUM_CLASSES-1:0][DH_W-1:0]  dh;
    logic [NUM_CLASSES-1:0][PCT_W-1:0] ds;
    logic [NUM_CLASSES-1:0][PCT_W-1:0] dl;
  } dist_stage_t;

  typedef struct packed {
    ctl_t                                ctl;
    logic [NUM_CLASSES-1:0][SCORE_W-1:0] score;
  } score_stage_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    color_class_t       cls;
  } cand_t;

endpackage

// ----- hw/rtl/hslrcc_dist.sv -----
// First pipeline stage: input normalisation, threshold tests and per-class distances.
`timescale 1ns / 1ps

module hslrcc_dist
  import hslrcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [HUE_W-1:0]   in_hue,
  input  logic [PCT_W-1:0]   in_saturation,
  input  logic [PCT_W-1:0]   in_luminosity,
  input  logic [SET_W-1:0]   in_target_set,
  input  logic [PCT_W-1:0]   white_lum,
  input  logic [PCT_W-1:0]   blue_sat,
  output dist_stage_t        dist_o
);

  logic [HUE_W-1:0] hue_n;
  logic [SET_W-1:0] set_n;
  dist_stage_t      dist_nxt;
  dist_stage_t      dist_r;

  // Fold hue into one turn and map the unused set code onto the field floor set.
  always_comb begin
    hue_n = (in_hue >= HUE_FULL) ? in_hue - HUE_FULL : in_hue;
    set_n = (in_target_set > SET_ARENA) ? SET_FIELD : in_target_set;
  end

  // Distances to every reference colour of the chosen set, hue wrapped at half a turn.
  always_comb begin
    logic [HUE_W-1:0] rh;
    logic [PCT_W-1:0] rs;
    logic [PCT_W-1:0] rl;
    logic [HUE_W-1:0] dh_raw;
    logic [HUE_W-1:0] dh_wrap;
    dist_nxt.ctl.valid   = in_fire;
    dist_nxt.ctl.white   = (in_luminosity >= white_lum);
    dist_nxt.ctl.blue_ok = (in_saturation > blue_sat);
    for (int c = 0; c < NUM_CLASSES; c++) begin
      rh      = REF_ROM[set_n][c].h;
      rs      = REF_ROM[set_n][c].s;
      rl      = REF_ROM[set_n][c].l;
      dh_raw  = (rh > hue_n) ? rh - hue_n : hue_n - rh;
      dh_wrap = (dh_raw > HUE_HALF) ? HUE_FULL - dh_raw : dh_raw;
      dist_nxt.dh[c] = dh_wrap[DH_W-1:0];
      dist_nxt.ds[c] = (rs > in_saturation) ? rs - in_saturation : in_saturation - rs;
      dist_nxt.dl[c] = (rl > in_luminosity) ? rl - in_luminosity : in_luminosity - rl;
    end
  end

  // Stage register, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= '0;
    end else begin
      dist_r <= dist_nxt;
    end
  end

  assign dist_o = dist_r;

endmodule

// ----- hw/rtl/hslrcc_score.sv -----
// Second pipeline stage: Gaussian table lookups and weighted score per class.
`timescale 1ns / 1ps

module hslrcc_score
  import hslrcc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  dist_stage_t  dist_i,
  output score_stage_t score_o
);

  score_stage_t score_nxt;
  score_stage_t score_r;

  // Doubled score: 4*G(hue) + 2*G(saturation) + G(luminosity), exact in integers.
  always_comb begin
    logic [GAUSS_W-1:0] gh;
    logic [GAUSS_W-1:0] gs;
    logic [GAUSS_W-1:0] gl;
    score_nxt.ctl = dist_i.ctl;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      gh = GTAB[dist_i.dh[c]];
      gs = GTAB[GIDX_W'(dist_i.ds[c])];
      gl = GTAB[GIDX_W'(dist_i.dl[c])];
      score_nxt.score[c] = (SCORE_W'(gh) << 2) + (SCORE_W'(gs) << 1) + SCORE_W'(gl);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r <= '0;
    end else begin
      score_r <= score_nxt;
    end
  end

  assign score_o = score_r;

endmodule

// ----- hw/rtl/hslrcc_select.sv -----
// Third and fourth pipeline stages: tie-keeping maximum search and result register.
`timescale 1ns / 1ps

module hslrcc_select
  import hslrcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  score_stage_t        score_i,
  output logic                out_valid,
  output logic [CLASS_W-1:0]  out_color_class
);

  localparam int NUM_PAIRS = NUM_CLASSES / 2;

  ctl_t                       ctl3_nxt;
  ctl_t                       ctl3_r;
  cand_t [NUM_PAIRS-1:0]      pair_nxt;
  cand_t [NUM_PAIRS-1:0]      pair_r;
  logic                       out_valid_nxt;
  logic                       out_valid_r;
  color_class_t               class_nxt;
  color_class_t               class_r;

  // Pairwise compare: the later class wins only on a strictly higher score,
  // and blue only when the saturation test passed.
  always_comb begin
    logic en_b;
    ctl3_nxt = score_i.ctl;
    for (int p = 0; p < NUM_PAIRS; p++) begin
      en_b = (color_class_t'(2 * p + 1) != CLS_BLUE) || score_i.ctl.blue_ok;
      if (en_b && (score_i.score[2 * p + 1] > score_i.score[2 * p])) begin
        pair_nxt[p].score = score_i.score[2 * p + 1];
        pair_nxt[p].cls   = color_class_t'(2 * p + 1);
      end else begin
        pair_nxt[p].score = score_i.score[2 * p];
        pair_nxt[p].cls   = color_class_t'(2 * p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
      pair_r <= '0;
    end else begin
      ctl3_r <= ctl3_nxt;
      pair_r <= pair_nxt;
    end
  end

  // Combine the pair winners in class order, then apply the white override.
  always_comb begin
    cand_t best;
    best = pair_r[0];
    for (int p = 1; p < NUM_PAIRS; p++) begin
      if (pair_r[p].score > best.score) best = pair_r[p];
    end
    out_valid_nxt = ctl3_r.valid;
    class_nxt     = ctl3_r.white ? CLS_WHITE : best.cls;
  end

  // Result register: the strobe and class are held for exactly one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_r     <= CLS_WHITE;
      out_valid_r <= 1'b0;
    end else begin
      class_r     <= class_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_color_class = class_r;

endmodule

// ----- hw/rtl/hsl_reference_color_classifier.sv -----
// Top level of the HSL reference colour classifier: configuration registers and pipeline.
//
//  Channel   Ports                                          Transaction when
//  --------  ---------------------------------------------  -----------------------------
//  input     start, busy, in_hue, in_saturation,            start high, busy low
//            in_luminosity, in_target_set
//  result    out_valid, out_color_class                     out_valid high (one cycle)
//  config    cfg_we, cfg_index, cfg_wdata                   cfg_we high
//
// Four register stages (distances, scores, pair compare, result register) lie between
// start and out_valid, and the pipeline takes one transaction per cycle.
// busy is always low: every stage advances each cycle, so nothing ever stalls.
// Reset (synchronous, active low) clears the valid bits and loads the thresholds.
`timescale 1ns / 1ps

module hsl_reference_color_classifier
  import hslrcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [HUE_W-1:0]     in_hue,
  input  logic [PCT_W-1:0]     in_saturation,
  input  logic [PCT_W-1:0]     in_luminosity,
  input  logic [SET_W-1:0]     in_target_set,
  output logic                 out_valid,
  output logic [CLASS_W-1:0]   out_color_class,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PCT_W-1:0]     cfg_wdata
);

  logic         in_fire;
  logic [PCT_W-1:0] white_lum_r;
  logic [PCT_W-1:0] white_lum_nxt;
  logic [PCT_W-1:0] blue_sat_r;
  logic [PCT_W-1:0] blue_sat_nxt;
  dist_stage_t  dist_data;
  score_stage_t score;

  // The pipeline takes a transaction in every cycle.
  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  // Configuration register decode.
  always_comb begin
    white_lum_nxt = white_lum_r;
    blue_sat_nxt  = blue_sat_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_WHITE_LUM: white_lum_nxt = cfg_wdata;
        CFG_BLUE_SAT:  blue_sat_nxt  = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_lum_r <= WHITE_LUM_RESET;
      blue_sat_r  <= BLUE_SAT_RESET;
    end else begin
      white_lum_r <= white_lum_nxt;
      blue_sat_r  <= blue_sat_nxt;
    end
  end

  hslrcc_dist u_dist (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_luminosity (in_luminosity),
    .in_target_set (in_target_set),
    .white_lum     (white_lum_r),
    .blue_sat      (blue_sat_r),
    .dist_o        (dist_data)
  );

  hslrcc_score u_score (
    .clk     (clk),
    .rst_n   (rst_n),
    .dist_i  (dist_data),
    .score_o (score)
  );

  hslrcc_select u_select (
    .clk             (clk),
    .rst_n           (rst_n),
    .score_i         (score),
    .out_valid       (out_valid),
    .out_color_class (out_color_class)
  );

endmodule

// ----- hw/rtl/hslrcc_checker.sv -----
// Port-level checker for the HSL colour classifier and its bind to the top level.
`timescale 1ns / 1ps

module hslrcc_checker
  import hslrcc_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input logic [CLASS_W-1:0]   out_color_class
);

  // Every accepted transaction yields a result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_DEPTH out_valid)
    else $error("accepted transaction produced no result");

  // No result appears without a transaction accepted at the fixed latency before.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result without a matching transaction");

  // A result class is always one of the six defined colours.
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_color_class <= CLASS_W'(CLS_BLUE)))
    else $error("result class out of range");

endmodule

bind hsl_reference_color_classifier hslrcc_checker u_hslrcc_checker (.*);

// ----- tb/tb_hsl_reference_color_classifier.sv -----
// Self-checking testbench for the HSL reference colour classifier.
`timescale 1ns / 1ps

module tb_hsl_reference_color_classifier;
  import hslrcc_pkg::*;

  // Gaussian table resolution and spread used by the class predictor.
  localparam int GAUSS_BITS = 12;
  localparam int SPREAD     = 10;
  localparam int GAUSS_LEN  = 181;

  // Cycles without any transaction before the run is declared hung.
  localparam int HANG_LIMIT = 2000;

  // Reference colours per set, in class order white, black, red, yellow, green, blue.
  localparam int REF_H [3][6] = '{'{300, 252, 3, 40, 125, 218},
                                  '{300, 252, 2, 38, 142, 220},
                                  '{300, 252, 3, 40, 125, 218}};
  localparam int REF_S [3][6] = '{'{5, 24, 53, 57, 56, 81},
                                  '{5, 24, 84, 84, 70, 96},
                                  '{5, 24, 53, 57, 56, 81}};
  localparam int REF_L [3][6] = '{'{100, 4, 52, 58, 35, 42},
                                  '{100, 4, 22, 23, 11, 23},
                                  '{100, 4, 52, 58, 35, 42}};

  typedef struct {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] lum;
    logic [SET_W-1:0] tset;
    bit               drain_first;
  } sample_t;

  typedef struct {
    sample_t      smp;
    color_class_t cls;
  } class_check_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [HUE_W-1:0] in_hue = '0;
  logic [PCT_W-1:0] in_saturation = '0;
  logic [PCT_W-1:0] in_luminosity = '0;
  logic [SET_W-1:0] in_target_set = '0;
  logic out_valid;
  logic [CLASS_W-1:0] out_color_class;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WHITE_LUM;
  logic [PCT_W-1:0] cfg_wdata = '0;

  // Samples waiting to be sent and class results still owed by the block.
  sample_t      sample_q[$];
  class_check_t class_q[$];

  // Predictor copy of the thresholds and the Gaussian weights.
  int unsigned white_thr = 100;
  int unsigned blue_thr = 70;
  int unsigned gauss_w [GAUSS_LEN];

  int sent_cnt = 0;
  int got_cnt = 0;
  int err_cnt = 0;
  int idle_pct = 0;
  int hang_cnt = 0;

  hsl_reference_color_classifier DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_hue          (in_hue),
    .in_saturation   (in_saturation),
    .in_luminosity   (in_luminosity),
    .in_target_set   (in_target_set),
    .out_valid       (out_valid),
    .out_color_class (out_color_class),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fills the Gaussian weights from the Q32 integer series for exp(-1/(2 sigma^2)),
  // raised to d^2 by successive odd powers, each rounded half up to GAUSS_BITS.
  function automatic void build_gauss_weights();
    bit [63:0] divisor;
    bit [63:0] term;
    bit [63:0] plus_sum;
    bit [63:0] minus_sum;
    bit [63:0] decay;
    bit [63:0] decay_sq;
    bit [63:0] step;
    bit [63:0] acc;
    bit [63:0] round_half;
    divisor   = 64'(2 * SPREAD * SPREAD);
    term      = 64'd1 << 32;
    plus_sum  = '0;
    minus_sum = '0;
    for (int k = 0; k < 12; k++) begin
      if (k > 0) term = term / (divisor * 64'(k));
      if (k % 2 == 0) plus_sum = plus_sum + term;
      else minus_sum = minus_sum + term;
    end
    decay      = plus_sum - minus_sum;
    decay_sq   = (decay * decay) >> 32;
    acc        = 64'd1 << 32;
    step       = decay;
    round_half = 64'd1 << (31 - GAUSS_BITS);
    for (int d = 0; d < GAUSS_LEN; d++) begin
      if (d > 0) begin
        acc  = (acc * step) >> 32;
        step = (step * decay_sq) >> 32;
      end
      gauss_w[d] = int'((acc + round_half) >> (32 - GAUSS_BITS));
    end
  endfunction

  function automatic int unsigned abs_diff(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Doubled score of one reference colour: 4 G(hue) + 2 G(sat) + G(lum).
  function automatic int unsigned ref_score(int rset, int c, int h, int s, int l);
    int unsigned dh;
    dh = abs_diff(REF_H[rset][c], h);
    if (dh > 180) dh = 360 - dh;
    return 4 * gauss_w[dh] + 2 * gauss_w[abs_diff(REF_S[rset][c], s)]
           + gauss_w[abs_diff(REF_L[rset][c], l)];
  endfunction

  // Class that the block must give for one sample under the current thresholds.
  function automatic color_class_t predict_class(sample_t smp);
    int           h;
    int           rset;
    int unsigned  best;
    int unsigned  pts;
    color_class_t winner;
    h    = int'(smp.hue);
    rset = (smp.tset > SET_ARENA) ? int'(SET_FIELD) : int'(smp.tset);
    if (h >= 360) h = h - 360;
    if (smp.lum >= white_thr) return CLS_WHITE;
    winner = CLS_WHITE;
    best   = ref_score(rset, int'(CLS_WHITE), h, smp.sat, smp.lum);
    for (int c = int'(CLS_BLACK); c <= int'(CLS_BLUE); c++) begin
      pts = ref_score(rset, c, h, smp.sat, smp.lum);
      // Later colours must beat the best strictly; blue also needs saturation.
      if (pts > best && (c != int'(CLS_BLUE) || smp.sat > blue_thr)) begin
        best   = pts;
        winner = color_class_t'(c);
      end
    end
    return winner;
  endfunction

  task automatic note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  task automatic add_sample(int h, int s, int l, int t, bit drain);
    sample_t smp;
    smp.hue         = HUE_W'(h);
    smp.sat         = PCT_W'(s);
    smp.lum         = PCT_W'(l);
    smp.tset        = SET_W'(t);
    smp.drain_first = drain;
    sample_q.push_back(smp);
  endtask

  function automatic int clamp_pct(int v);
    return (v < 0) ? 0 : ((v > 127) ? 127 : v);
  endfunction

  // Random sample: often near a reference colour, more often in the legal ranges,
  // and less often anywhere the field widths allow.
  task automatic add_random_sample();
    int pick;
    int rset;
    int c;
    bit drain;
    pick  = $urandom_range(99);
    drain = ($urandom_range(49) == 0);
    if (pick < 40) begin
      rset = $urandom_range(2);
      c    = $urandom_range(5);
      add_sample((REF_H[rset][c] + 345 + $urandom_range(30)) % 360,
                 clamp_pct(REF_S[rset][c] + int'($urandom_range(30)) - 15),
                 clamp_pct(REF_L[rset][c] + int'($urandom_range(30)) - 15),
                 rset, drain);
    end else if (pick < 85) begin
      add_sample($urandom_range(359), $urandom_range(100), $urandom_range(100),
                 $urandom_range(2), drain);
    end else begin
      add_sample($urandom_range(511), $urandom_range(127), $urandom_range(127),
                 $urandom_range(3), drain);
    end
  endtask

  // Waits at a rising edge until every sample is sent and every class has come back,
  // then lets the pipeline settle.
  task automatic wait_drained();
    while (sample_q.size() != 0 || sent_cnt != got_cnt) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // Writes both thresholds on consecutive edges; called with the block idle.
  task automatic set_thresholds(int unsigned white_lvl, int unsigned blue_lvl);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WHITE_LUM;
    cfg_wdata <= PCT_W'(white_lvl);
    @(posedge clk);
    cfg_index <= CFG_BLUE_SAT;
    cfg_wdata <= PCT_W'(blue_lvl);
    @(posedge clk);
    cfg_we    <= 1'b0;
    white_thr = white_lvl;
    blue_thr  = blue_lvl;
  endtask

  task automatic run_random(int n, int idle);
    @(negedge clk);
    idle_pct = idle;
    for (int i = 0; i < n; i++) add_random_sample();
    wait_drained();
  endtask

  // Driver: records each accepted transaction with its predicted class and
  // presents the next queued sample unless the sender idles or that sample must wait to drain.
  always @(posedge clk) begin
    logic         took;
    logic         present;
    class_check_t chk;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        chk.smp.hue         = in_hue;
        chk.smp.sat         = in_saturation;
        chk.smp.lum         = in_luminosity;
        chk.smp.tset        = in_target_set;
        chk.smp.drain_first = 1'b0;
        chk.cls             = predict_class(chk.smp);
        class_q.push_back(chk);
        sent_cnt <= sent_cnt + 1;
        void'(sample_q.pop_front());
      end
      present = 1'b0;
      if (sample_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        // A draining sample waits until no class result is owed.
        if (!sample_q[0].drain_first) present = 1'b1;
        else if (!took && sent_cnt == got_cnt) present = 1'b1;
      end
      start <= present;
      if (present) begin
        in_hue        <= sample_q[0].hue;
        in_saturation <= sample_q[0].sat;
        in_luminosity <= sample_q[0].lum;
        in_target_set <= sample_q[0].tset;
      end
    end
  end

  // Monitor: checks each result transaction against the oldest owed class.
  always @(posedge clk) begin
    class_check_t chk;
    if (rst_n && out_valid) begin
      if (sent_cnt == got_cnt) begin
        note_error($sformatf("Unexpected result: class %0d with nothing owed",
                             out_color_class));
      end else begin
        chk = class_q.pop_front();
        got_cnt <= got_cnt + 1;
        if (out_color_class !== chk.cls) begin
          note_error($sformatf(
            "Mismatch: hue %0d sat %0d lum %0d set %0d: expected class %0d (%s), got %0d",
            chk.smp.hue, chk.smp.sat, chk.smp.lum, chk.smp.tset, chk.cls,
            chk.cls.name(), out_color_class));
        end
      end
    end
  end

  // Watchdog: ends the run if no transaction of either kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      hang_cnt <= 0;
    end else if (hang_cnt >= HANG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      hang_cnt <= hang_cnt + 1;
    end
  end

  initial begin
    build_gauss_weights();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed samples at the reset thresholds.
    @(negedge clk);
    idle_pct = 0;
    add_sample(0, 0, 0, 0, 0);
    add_sample(359, 100, 99, 1, 0);
    add_sample(511, 127, 127, 3, 0);      // every field at its widest
    add_sample(360, 53, 52, 0, 0);        // hue that wraps to zero
    add_sample(125, 56, 100, 2, 0);       // luminosity on the white threshold
    add_sample(300, 5, 99, 0, 0);         // just below it, on the white reference
    add_sample(252, 24, 4, 0, 0);
    add_sample(2, 84, 22, 1, 0);
    add_sample(38, 84, 23, 1, 0);
    add_sample(142, 70, 11, 1, 0);
    add_sample(220, 96, 23, 1, 0);
    add_sample(218, 81, 42, 0, 0);
    add_sample(218, 70, 42, 0, 1);        // saturation equal to the blue threshold
    add_sample(218, 71, 42, 0, 0);        // one above it
    add_sample(183, 53, 52, 0, 0);        // hue distance of exactly half a turn
    add_sample(184, 0, 0, 1, 0);
    add_sample(40, 57, 58, 2, 0);
    add_sample(125, 56, 35, 3, 0);        // unused set code falls back to the field floor
    add_sample(256, 64, 64, 1, 0);
    add_sample(218, 127, 0, 0, 0);
    add_sample(470, 96, 23, 3, 0);        // hue above a full turn, folding to 110
    add_sample(300, 5, 100, 1, 0);
    wait_drained();

    // Random phases through extreme and ordinary threshold settings.
    set_thresholds(0, 0);
    run_random(60, 55);
    set_thresholds(127, 127);
    run_random(100, 7);
    set_thresholds(100, 70);
    run_random(300, 0);
    set_thresholds(60, 40);
    run_random(200, 55);
    set_thresholds($urandom_range(127), $urandom_range(127));
    run_random(140, 7);

    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/hslrcc_pkg.sv
hw/rtl/hslrcc_dist.sv
hw/rtl/hslrcc_score.sv
hw/rtl/hslrcc_select.sv
hw/rtl/hsl_reference_color_classifier.sv
hw/rtl/hslrcc_checker.sv
tb/tb_hsl_reference_color_classifier.sv
